// File: hw/rtl/rwbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwbc_pkg
// Shared types and constants of the register-window bytecode core.
// ----------------------------------------------------------------------------
package rwbc_pkg;

  localparam int unsigned PROG_DEPTH = 4096;
  localparam int unsigned REG_DEPTH  = 131072;
  localparam int unsigned PW         = $clog2(PROG_DEPTH);
  localparam int unsigned RW         = $clog2(REG_DEPTH);
  localparam int unsigned WORD_W     = 46;

  typedef enum logic [5:0] {
    OP_ADDRR = 6'd0,  OP_MULRR = 6'd1,  OP_EQRR = 6'd2,  OP_NERR = 6'd3,
    OP_ADDRI = 6'd4,  OP_MULRI = 6'd5,  OP_EQRI = 6'd6,  OP_NERI = 6'd7,
    OP_SUBRR = 6'd8,  OP_DIVRR = 6'd9,  OP_MODRR = 6'd10, OP_LTRR = 6'd11,
    OP_LERR  = 6'd12, OP_SUBRI = 6'd13, OP_DIVRI = 6'd14, OP_MODRI = 6'd15,
    OP_LTRI  = 6'd16, OP_LERI  = 6'd17, OP_SUBIR = 6'd18, OP_DIVIR = 6'd19,
    OP_MODIR = 6'd20, OP_LTIR  = 6'd21, OP_LEIR  = 6'd22, OP_NEG   = 6'd23,
    OP_NOT   = 6'd24, OP_MOVI  = 6'd25, OP_MOVR  = 6'd26, OP_JMP   = 6'd27,
    OP_JT    = 6'd28, OP_JF    = 6'd29, OP_CALL  = 6'd30, OP_RETR  = 6'd31,
    OP_RETI  = 6'd32, OP_EXIT  = 6'd33, OP_IN    = 6'd34, OP_OUT   = 6'd35
  } op_t;

  // ALU operation kinds
  typedef enum logic [3:0] {
    K_ADD, K_MUL, K_EQ, K_NE, K_SUB, K_DIV, K_MOD, K_LT, K_LE
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_FETCH, S_DEC, S_RDB, S_RDC, S_RDA, S_EXEC,
    S_MUL, S_DIV, S_RDLINK, S_RDCW, S_WRITE, S_DONE
  } state_t;

  typedef struct packed {
    logic        cmd;
    logic [11:0] load_addr;
    logic [5:0]  opcode;
    logic [7:0]  field_a;
    logic [7:0]  field_b;
    logic [7:0]  field_c;
    logic signed [15:0] field_d;
    logic signed [63:0] in_value;
  } in_item_t;

  typedef struct packed {
    logic [11:0] pc;
    logic        in_used;
    logic        out_valid;
    logic signed [63:0] out_value;
    logic        halted;
    logic signed [31:0] exit_code;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic        is_rem;
    logic [63:0] x;
    logic [63:0] y;
  } div_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/rwbc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwbc_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module rwbc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

`default_nettype wire

// File: hw/rtl/rwbc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwbc_div
// Radix-2 signed divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rwbc_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rwbc_pkg::div_req_t req,
  output logic                   done,
  output logic [63:0]            result
);
  logic [63:0] rem_r, rem_nxt, quo_r, quo_nxt, den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, nq_r, nq_nxt, nr_r, nr_nxt, rm_r, rm_nxt;
  logic        zero_r, zero_nxt;
  logic [64:0] trial;
  logic [63:0] shifted;

  always_comb begin
    busy_nxt = busy_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    nq_nxt   = nq_r;
    nr_nxt   = nr_r;
    rm_nxt   = rm_r;
    zero_nxt = zero_r;
    shifted  = {rem_r[62:0], quo_r[63]};
    trial    = {1'b0, shifted} - {1'b0, den_r};
    done     = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      quo_nxt  = req.x[63] ? (64'd0 - req.x) : req.x;
      den_nxt  = req.y[63] ? (64'd0 - req.y) : req.y;
      nq_nxt   = req.x[63] ^ req.y[63];
      nr_nxt   = req.x[63];
      rm_nxt   = req.is_rem;
      zero_nxt = (req.y == '0);
      cnt_nxt  = 7'd64;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done     = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 7'd1;
        if (!trial[64]) begin
          rem_nxt = trial[63:0];
          quo_nxt = {quo_r[62:0], 1'b1};
        end else begin
          rem_nxt = shifted;
          quo_nxt = {quo_r[62:0], 1'b0};
        end
      end
    end
  end

  // Magnitude division wraps the overflow case to the correct pattern.
  always_comb begin
    if (zero_r) begin
      result = '0;
    end else if (rm_r) begin
      result = nr_r ? (64'd0 - rem_r) : rem_r;
    end else begin
      result = nq_r ? (64'd0 - quo_r) : quo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    den_r  <= den_nxt;
    cnt_r  <= cnt_nxt;
    nq_r   <= nq_nxt;
    nr_r   <= nr_nxt;
    rm_r   <= rm_nxt;
    zero_r <= zero_nxt;
  end
endmodule

`default_nettype wire

// File: hw/rtl/register_window_bytecode_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A load item writes one program word; a step item's time is set by the
// serial register store port (up to four reads and one write). MUL sums
// 16x64 partial products in S_MUL; DIV and MOD wait in S_DIV for the divider.
// One item is in work at a time; a result waits in the output register.
// After reset a clearing pass zeroes every word of the register store
// before the first item is accepted.
// ----------------------------------------------------------------------------
// register_window_bytecode_core
// Sequencer around a program RAM, a register RAM and a shared divider.
// ----------------------------------------------------------------------------
module register_window_bytecode_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire rwbc_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output rwbc_pkg::out_item_t       out_data
);
  localparam int unsigned PW = rwbc_pkg::PW;
  localparam int unsigned RW = rwbc_pkg::RW;

  rwbc_pkg::state_t state_r, state_nxt;

  logic [PW-1:0] pc_r, pc_nxt;
  logic [RW-1:0] fb_r, fb_nxt;
  logic          halt_r, halt_nxt;
  logic [RW:0]   clr_r, clr_nxt;
  logic          ov_r, ov_nxt;
  rwbc_pkg::out_item_t res_r, res_nxt;
  rwbc_pkg::in_item_t  itm_r, itm_nxt;

  // Decoded word
  logic [45:0] w_r, w_nxt;
  logic [63:0] x_r, x_nxt, y_r, y_nxt, a_r, a_nxt, v_r, v_nxt;
  logic [63:0] link_r, link_nxt;
  logic [1:0]  mstep_r, mstep_nxt;

  // Program RAM
  logic            p_we;
  logic [PW-1:0]   p_addr;
  logic [45:0]     p_wdata, p_rdata;
  // Register RAM
  logic            r_we;
  logic [RW-1:0]   r_addr;
  logic [63:0]     r_wdata, r_rdata;

  rwbc_pkg::div_req_t dreq;
  logic        ddone;
  logic [63:0] dres;

  rwbc_ram #(.WIDTH(46), .DEPTH(rwbc_pkg::PROG_DEPTH)) u_prog (
    .clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata));
  rwbc_ram #(.WIDTH(64), .DEPTH(rwbc_pkg::REG_DEPTH)) u_regs (
    .clk(clk), .we(r_we), .addr(r_addr), .wdata(r_wdata), .rdata(r_rdata));
  rwbc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .result(dres));

  logic [5:0]  op;
  logic [7:0]  fa, fb8, fc;
  logic [63:0] dx;
  logic [PW-1:0] nextpc, jumppc;
  rwbc_pkg::kind_t kind;
  logic [63:0] sb, sc;
  logic [63:0] pprod;

  assign op  = w_r[45:40];
  assign fa  = w_r[39:32];
  assign fb8 = w_r[31:24];
  assign fc  = w_r[23:16];
  assign dx  = {{48{w_r[15]}}, w_r[15:0]};
  assign sb  = {{56{fb8[7]}}, fb8};
  assign sc  = {{56{fc[7]}}, fc};
  assign nextpc = pc_r + PW'(1);
  assign jumppc = pc_r + dx[PW-1:0] + PW'(1);
  // one 16x64 partial product per cycle
  assign pprod = (y_r * {48'd0, x_r[16*mstep_r +: 16]}) << (16 * mstep_r);

  always_comb begin
    unique case (op)
      rwbc_pkg::OP_ADDRR, rwbc_pkg::OP_ADDRI: kind = rwbc_pkg::K_ADD;
      rwbc_pkg::OP_MULRR, rwbc_pkg::OP_MULRI: kind = rwbc_pkg::K_MUL;
      rwbc_pkg::OP_EQRR, rwbc_pkg::OP_EQRI:   kind = rwbc_pkg::K_EQ;
      rwbc_pkg::OP_NERR, rwbc_pkg::OP_NERI:   kind = rwbc_pkg::K_NE;
      rwbc_pkg::OP_SUBRR, rwbc_pkg::OP_SUBRI, rwbc_pkg::OP_SUBIR: kind = rwbc_pkg::K_SUB;
      rwbc_pkg::OP_DIVRR, rwbc_pkg::OP_DIVRI, rwbc_pkg::OP_DIVIR: kind = rwbc_pkg::K_DIV;
      rwbc_pkg::OP_MODRR, rwbc_pkg::OP_MODRI, rwbc_pkg::OP_MODIR: kind = rwbc_pkg::K_MOD;
      rwbc_pkg::OP_LTRR, rwbc_pkg::OP_LTRI, rwbc_pkg::OP_LTIR: kind = rwbc_pkg::K_LT;
      default: kind = rwbc_pkg::K_LE;
    endcase
  end

  assign in_ready  = (state_r == rwbc_pkg::S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data  = res_r;

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    fb_nxt    = fb_r;
    halt_nxt  = halt_r;
    clr_nxt   = clr_r;
    ov_nxt    = ov_r && !out_ready;
    res_nxt   = res_r;
    itm_nxt   = itm_r;
    w_nxt     = w_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    a_nxt     = a_r;
    v_nxt     = v_r;
    link_nxt  = link_r;
    mstep_nxt = mstep_r;
    p_we      = 1'b0;
    p_addr    = pc_r;
    p_wdata   = {itm_r.opcode, itm_r.field_a, itm_r.field_b, itm_r.field_c,
                 itm_r.field_d};
    r_we      = 1'b0;
    r_addr    = fb_r;
    r_wdata   = '0;
    dreq      = '0;
    unique case (state_r)
      rwbc_pkg::S_CLEAR: begin
        r_we    = 1'b1;
        r_addr  = clr_r[RW-1:0];
        clr_nxt = clr_r + (RW+1)'(1);
        if (clr_r[RW-1:0] == {RW{1'b1}}) begin
          state_nxt = rwbc_pkg::S_IDLE;
        end
      end
      rwbc_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          itm_nxt = in_data;
          res_nxt = '0;
          state_nxt = rwbc_pkg::S_FETCH;
        end
      end
      rwbc_pkg::S_FETCH: begin
        if (!itm_r.cmd) begin
          p_we = 1'b1;
          p_addr = itm_r.load_addr[PW-1:0];
          state_nxt = rwbc_pkg::S_DONE;
        end else if (halt_r) begin
          state_nxt = rwbc_pkg::S_DONE;
        end else begin
          state_nxt = rwbc_pkg::S_DEC;
        end
      end
      rwbc_pkg::S_DEC: begin
        w_nxt = p_rdata;
        r_addr = fb_r + RW'(p_rdata[31:24]);
        state_nxt = rwbc_pkg::S_RDB;
      end
      rwbc_pkg::S_RDB: begin
        x_nxt = r_rdata;
        r_addr = fb_r + RW'(fc);
        state_nxt = rwbc_pkg::S_RDC;
      end
      rwbc_pkg::S_RDC: begin
        y_nxt = r_rdata;
        r_addr = fb_r + RW'(fa);
        state_nxt = rwbc_pkg::S_RDA;
      end
      rwbc_pkg::S_RDA: begin
        a_nxt = r_rdata;
        if ((op >= 6'd4 && op <= 6'd7) || (op >= 6'd13 && op <= 6'd17)) begin
          y_nxt = sc;
        end else if (op >= 6'd18 && op <= 6'd22) begin
          x_nxt = sb;
        end
        state_nxt = rwbc_pkg::S_EXEC;
      end
      rwbc_pkg::S_EXEC: begin
        state_nxt = rwbc_pkg::S_WRITE;
        pc_nxt = nextpc;
        v_nxt = '0;
        if (op <= 6'd22) begin
          case (kind)
            rwbc_pkg::K_ADD: v_nxt = x_r + y_r;
            rwbc_pkg::K_SUB: v_nxt = x_r - y_r;
            rwbc_pkg::K_EQ:  v_nxt = {63'd0, x_r == y_r};
            rwbc_pkg::K_NE:  v_nxt = {63'd0, x_r != y_r};
            rwbc_pkg::K_LT:  v_nxt = {63'd0, $signed(x_r) < $signed(y_r)};
            rwbc_pkg::K_LE:  v_nxt = {63'd0, $signed(x_r) <= $signed(y_r)};
            rwbc_pkg::K_MUL: begin
              mstep_nxt = '0;
              state_nxt = rwbc_pkg::S_MUL;
            end
            default: begin
              dreq.start = 1'b1;
              dreq.is_rem = (kind == rwbc_pkg::K_MOD);
              dreq.x = x_r;
              dreq.y = y_r;
              state_nxt = rwbc_pkg::S_DIV;
            end
          endcase
        end else begin
          unique case (op)
            rwbc_pkg::OP_NEG:  v_nxt = 64'd0 - x_r;
            rwbc_pkg::OP_NOT:  v_nxt = {63'd0, x_r == '0};
            rwbc_pkg::OP_MOVI: v_nxt = dx;
            rwbc_pkg::OP_MOVR: v_nxt = x_r;
            rwbc_pkg::OP_JMP: begin
              pc_nxt = jumppc;
              state_nxt = rwbc_pkg::S_DONE;
            end
            rwbc_pkg::OP_JT: begin
              pc_nxt = (a_r != '0) ? jumppc : nextpc;
              state_nxt = rwbc_pkg::S_DONE;
            end
            rwbc_pkg::OP_JF: begin
              pc_nxt = (a_r == '0) ? jumppc : nextpc;
              state_nxt = rwbc_pkg::S_DONE;
            end
            rwbc_pkg::OP_CALL: begin
              pc_nxt = pc_r + a_r[PW-1:0] + PW'(1);
              v_nxt = {{(64-PW){1'b0}}, pc_r};
            end
            rwbc_pkg::OP_RETR, rwbc_pkg::OP_RETI: begin
              pc_nxt = pc_r;
              v_nxt = (op == rwbc_pkg::OP_RETR) ? a_r : dx;
              r_addr = fb_r - RW'(1);
              state_nxt = rwbc_pkg::S_RDLINK;
            end
            rwbc_pkg::OP_EXIT: begin
              pc_nxt = pc_r;
              halt_nxt = 1'b1;
              res_nxt.exit_code = a_r[31:0];
              state_nxt = rwbc_pkg::S_DONE;
            end
            rwbc_pkg::OP_IN: begin
              v_nxt = itm_r.in_value;
              res_nxt.in_used = 1'b1;
            end
            rwbc_pkg::OP_OUT: begin
              res_nxt.out_valid = 1'b1;
              res_nxt.out_value = a_r;
              state_nxt = rwbc_pkg::S_DONE;
            end
            default: state_nxt = rwbc_pkg::S_DONE;
          endcase
        end
      end
      rwbc_pkg::S_MUL: begin
        v_nxt = (mstep_r == '0) ? pprod : v_r + pprod;
        mstep_nxt = mstep_r + 2'd1;
        if (mstep_r == 2'd3) begin
          state_nxt = rwbc_pkg::S_WRITE;
        end
      end
      rwbc_pkg::S_DIV: begin
        if (ddone) begin
          v_nxt = dres;
          state_nxt = rwbc_pkg::S_WRITE;
        end
      end
      rwbc_pkg::S_RDLINK: begin
        link_nxt = r_rdata;
        p_addr = r_rdata[PW-1:0];
        state_nxt = rwbc_pkg::S_RDCW;
      end
      rwbc_pkg::S_RDCW: begin
        // write return value over the link, slide the frame down
        r_we = 1'b1;
        r_addr = fb_r - RW'(1);
        r_wdata = v_r;
        fb_nxt = fb_r - RW'(p_rdata[39:32]) - RW'(1);
        pc_nxt = link_r[PW-1:0] + PW'(1);
        state_nxt = rwbc_pkg::S_DONE;
      end
      rwbc_pkg::S_WRITE: begin
        r_we = 1'b1;
        r_addr = fb_r + RW'(fa);
        r_wdata = v_r;
        if (op == rwbc_pkg::OP_CALL) begin
          fb_nxt = fb_r + RW'(fa) + RW'(1);
        end
        state_nxt = rwbc_pkg::S_DONE;
      end
      rwbc_pkg::S_DONE: begin
        res_nxt.pc = 12'(pc_nxt);
        res_nxt.halted = halt_r;
        ov_nxt = 1'b1;
        state_nxt = rwbc_pkg::S_IDLE;
      end
      default: state_nxt = rwbc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rwbc_pkg::S_CLEAR;
      pc_r    <= '0;
      fb_r    <= '0;
      halt_r  <= 1'b0;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      fb_r    <= fb_nxt;
      halt_r  <= halt_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
    res_r   <= res_nxt;
    itm_r   <= itm_nxt;
    w_r     <= w_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    a_r     <= a_nxt;
    v_r     <= v_nxt;
    link_r  <= link_nxt;
    mstep_r <= mstep_nxt;
  end
endmodule

`default_nettype wire

// File: sim/tb_register_window_bytecode_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_register_window_bytecode_core
// Self-checking bench: load programs, step them, compare every result item
// with a behavioral copy of the core kept in the bench.
// ----------------------------------------------------------------------------
module tb_register_window_bytecode_core;
  import rwbc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  always #5 clk = ~clk;

  register_window_bytecode_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Shadow machine state.
  logic [WORD_W-1:0] code_mem [PROG_DEPTH];
  logic [63:0] regs [REG_DEPTH];
  logic [PW-1:0] cur_pc;
  logic [RW-1:0] fbase;
  logic stopped;

  in_item_t pending_items [$];
  out_item_t expected_results [$];
  int mismatches = 0;
  int n_steps = 0;
  int n_outs = 0;
  int n_loads = 0;
  bit stim_done = 1'b0;

  function automatic logic [63:0] rd(input logic [7:0] idx);
    rd = regs[RW'(fbase + RW'(idx))];
  endfunction

  function automatic logic [63:0] sdivide(input logic [63:0] x, input logic [63:0] y,
                                          input bit rem);
    logic signed [63:0] sx, sy;
    sx = x;
    sy = y;
    if (y == 0) return 64'd0;
    if (sy == -64'sd1) return rem ? 64'd0 : -x;
    return rem ? 64'(sx % sy) : 64'(sx / sy);
  endfunction

  // Return: link sits just below the frame, its low bits point at the call word.
  task automatic unwind(input logic [63:0] retval);
    logic [RW-1:0] link;
    logic [PW-1:0] cpc;
    logic [7:0] ca;
    link = fbase - 1'b1;
    cpc = regs[link][PW-1:0];
    ca = code_mem[cpc][39:32];
    regs[link] = retval;
    fbase = fbase - RW'({1'b0, ca} + 9'd1);
    cur_pc = cpc + 1'b1;
  endtask

  // Work out the result item one accepted input item causes.
  task automatic execute_item(input in_item_t it);
    out_item_t r;
    logic [WORD_W-1:0] w;
    logic [5:0] op;
    logic [7:0] a, b, c;
    logic [63:0] d, x, y, av;
    logic [RW-1:0] ra;
    logic [PW-1:0] nxt, jmp;
    r = '0;
    if (!it.cmd) begin
      code_mem[it.load_addr] = {it.opcode, it.field_a, it.field_b, it.field_c, it.field_d};
      n_loads++;
    end else if (!stopped) begin
      n_steps++;
      w = code_mem[cur_pc];
      op = w[45:40]; a = w[39:32]; b = w[31:24]; c = w[23:16];
      d = {{48{w[15]}}, w[15:0]};
      ra = RW'(fbase + RW'(a));
      av = regs[ra];
      nxt = cur_pc + 1'b1;
      jmp = cur_pc + PW'(d) + 1'b1;
      x = rd(b);
      y = rd(c);
      if ((op >= OP_ADDRI && op <= OP_NERI) || (op >= OP_SUBRI && op <= OP_LERI))
        y = {{56{c[7]}}, c};
      else if (op >= OP_SUBIR && op <= OP_LEIR)
        x = {{56{b[7]}}, b};
      cur_pc = nxt;
      case (op)
        OP_ADDRR, OP_ADDRI: regs[ra] = x + y;
        OP_MULRR, OP_MULRI: regs[ra] = x * y;
        OP_EQRR, OP_EQRI: regs[ra] = 64'(x == y);
        OP_NERR, OP_NERI: regs[ra] = 64'(x != y);
        OP_SUBRR, OP_SUBRI, OP_SUBIR: regs[ra] = x - y;
        OP_DIVRR, OP_DIVRI, OP_DIVIR: regs[ra] = sdivide(x, y, 1'b0);
        OP_MODRR, OP_MODRI, OP_MODIR: regs[ra] = sdivide(x, y, 1'b1);
        OP_LTRR, OP_LTRI, OP_LTIR: regs[ra] = 64'($signed(x) < $signed(y));
        OP_LERR, OP_LERI, OP_LEIR: regs[ra] = 64'($signed(x) <= $signed(y));
        OP_NEG: regs[ra] = -x;
        OP_NOT: regs[ra] = 64'(x == 0);
        OP_MOVI: regs[ra] = d;
        OP_MOVR: regs[ra] = x;
        OP_JMP: cur_pc = jmp;
        OP_JT: if (av != 0) cur_pc = jmp;
        OP_JF: if (av == 0) cur_pc = jmp;
        OP_CALL: begin
          // target offset is the full register; only its low bits matter mod depth
          cur_pc = nxt - 1'b1 + PW'(av) + 1'b1;
          regs[ra] = 64'(nxt - 1'b1);
          fbase = fbase + RW'(a) + 1'b1;
        end
        OP_RETR: unwind(av);
        OP_RETI: unwind(d);
        OP_EXIT: begin
          stopped = 1'b1;
          cur_pc = nxt - 1'b1;
          r.exit_code = av[31:0];
        end
        OP_IN: begin
          regs[ra] = it.in_value;
          r.in_used = 1'b1;
        end
        OP_OUT: begin
          r.out_valid = 1'b1;
          r.out_value = av;
          n_outs++;
        end
        default: ;
      endcase
    end
    r.pc = cur_pc;
    r.halted = stopped;
    expected_results.push_back(r);
  endtask

  // Driver: hold valid and payload until taken, then send the next or pause.
  int in_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(0, 3) != 0) begin
          in_data <= pending_items.pop_front();
          in_gap <= 0;
        end else begin
          in_valid <= 1'b0;
          in_gap <= $urandom_range(0, 11);
        end
      end else if (!in_valid) begin
        if (in_gap > 0) in_gap <= in_gap - 1;
        else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Receiver stalls: draw a wait count per result.
  int out_wait = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        out_wait = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) out_wait = 0;
      end
      if (out_wait > 0) begin
        out_ready <= 1'b0;
        out_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on input accept, compare on output accept.
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n) begin
      if (in_valid && in_ready) execute_item(in_data);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item: %p", out_data);
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r !== out_data) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got %p", exp_r, out_data);
          end
        end
      end
    end
  end

  // Stimulus helpers.
  function automatic in_item_t mk_load(input logic [11:0] addr, input op_t op,
                                       input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c, input logic [15:0] d);
    in_item_t it;
    it = '0;
    it.cmd = 1'b0;
    it.load_addr = addr;
    it.opcode = op;
    it.field_a = a; it.field_b = b; it.field_c = c; it.field_d = d;
    it.in_value = {$urandom, $urandom};
    return it;
  endfunction

  function automatic in_item_t mk_step(input logic [63:0] v);
    in_item_t it;
    it = '0;
    it.cmd = 1'b1;
    it.load_addr = 12'($urandom);
    it.opcode = 6'($urandom);
    it.field_a = 8'($urandom); it.field_b = 8'($urandom);
    it.field_c = 8'($urandom); it.field_d = 16'($urandom);
    it.in_value = v;
    return it;
  endfunction

  function automatic logic [63:0] rnd_value();
    case ($urandom_range(0, 5))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return '1;
      3: return 64'($urandom_range(0, 8));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Fill all of program memory so no step ever fetches an unwritten word.
  // Most words are halt-free straight-line ops over a small register window.
  function automatic in_item_t rnd_word(input logic [11:0] addr);
    op_t op;
    logic [7:0] a, b, c;
    logic [15:0] d;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) op = op_t'($urandom_range(OP_ADDRR, OP_MOVR));
    else if (sel < 72) op = op_t'($urandom_range(OP_JMP, OP_JF));
    else if (sel < 78) op = OP_CALL;
    else if (sel < 86) op = op_t'($urandom_range(OP_RETR, OP_RETI));
    else if (sel < 93) op = OP_IN;
    else op = OP_OUT;
    a = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    b = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    c = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    d = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 16)) - 8);
    return mk_load(addr, op, a, b, c, d);
  endfunction

  int rnd_steps;

  initial begin
    // Directed: a short program covering edge immediates, MOD, divide by zero,
    // min/-1, call/return, IN/OUT, then filled memory, then EXIT at the end.
    pending_items.push_back(mk_load(12'd0, OP_IN, 8'd1, 8'd0, 8'd0, 16'd0));
    pending_items.push_back(mk_load(12'd1, OP_MOVI, 8'd2, 8'd0, 8'd0, 16'h8000));
    pending_items.push_back(mk_load(12'd2, OP_MODRI, 8'd3, 8'd1, 8'hfd, 16'd0));
    pending_items.push_back(mk_load(12'd3, OP_DIVRR, 8'd4, 8'd1, 8'd5, 16'd0));
    pending_items.push_back(mk_load(12'd4, OP_DIVRI, 8'd4, 8'd1, 8'hff, 16'd0));
    pending_items.push_back(mk_load(12'd5, OP_SUBIR, 8'd5, 8'h7f, 8'd2, 16'h7fff));
    pending_items.push_back(mk_load(12'd6, OP_OUT, 8'd3, 8'd0, 8'd0, 16'd0));
    pending_items.push_back(mk_load(12'd7, OP_CALL, 8'd6, 8'd0, 8'd0, 16'd0));
    pending_items.push_back(mk_load(12'd8, OP_RETI, 8'hff, 8'hff, 8'hff, 16'hffff));
    pending_items.push_back(mk_load(12'hfff, OP_OUT, 8'hff, 8'hff, 8'hff, 16'hffff));
    pending_items.push_back(mk_step(64'h8000_0000_0000_0000));
    for (int i = 0; i < 8; i++) pending_items.push_back(mk_step(rnd_value()));
    // Fill memory; keep the directed words at 0..8 and 0xfff.
    for (int i = 9; i < PROG_DEPTH - 1; i++)
      pending_items.push_back(rnd_word(12'(i)));
    // Random stepping with occasional reloads of random words.
    rnd_steps = 0;
    while (rnd_steps < 1100) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_items.push_back(rnd_word(12'($urandom_range(9, PROG_DEPTH - 2))));
      end else begin
        pending_items.push_back(mk_step(rnd_value()));
        rnd_steps++;
      end
    end
    // Place an EXIT at the current shadow pc is not known here; load EXIT
    // everywhere reachable is too costly, so plant it over word 9 and jump there.
    pending_items.push_back(mk_load(12'd9, OP_EXIT, 8'd1, 8'd0, 8'd0, 16'd0));
    pending_items.push_back(mk_load(12'hfff, OP_JMP, 8'd0, 8'd0, 8'd0, 16'd9));
    for (int i = 10; i < PROG_DEPTH - 1; i++)
      pending_items.push_back(mk_load(12'(i), OP_JMP, 8'd0, 8'd0, 8'd0, 16'($signed(-i))));
    for (int i = 0; i < 9; i++)
      pending_items.push_back(mk_load(12'(i), OP_JMP, 8'd0, 8'd0, 8'd0, 16'(8 - i)));
    for (int i = 0; i < 3; i++) pending_items.push_back(mk_step(rnd_value()));
    pending_items.push_back(mk_load(12'd3, OP_ADDRR, 8'd1, 8'd1, 8'd1, 16'd0));

    repeat (4) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    wait (pending_items.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    stim_done = 1'b1;
    $display("covered %0d loads, %0d executed steps, %0d OUT results", n_loads, n_steps,
             n_outs);
    $display("final shadow pc %0d, halted %0b", cur_pc, stopped);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Shadow reset.
  initial begin
    for (int i = 0; i < REG_DEPTH; i++) regs[i] = '0;
    for (int i = 0; i < PROG_DEPTH; i++) code_mem[i] = '0;
    cur_pc = '0;
    fbase = '0;
    stopped = 1'b0;
  end

  // Timeout: clearing pass plus about 9.4k items plus stalls.
  initial begin
    #60ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
